@@ src/pabs_pkg.sv @@
// ----------------------------------------------------------------------------
// pabs_pkg
// Shared constants and helpers for the pressure-aware bank selector.
// ----------------------------------------------------------------------------
package pabs_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF      = 2;
    localparam int RANKS_DEF         = 2;
    localparam int MAX_SLOTS_DEF     = 16;
    localparam int ROWS_PER_BANK_DEF = 8192;

    // Free-count field
    localparam int CNT_W   = 14;
    localparam int CNT_MAX = 16383;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_GROUPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS       = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET       = 3'd4;

    // splitmix64 constants
    localparam logic [63:0] MIX_GOLD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2   = 64'h94d049bb133111eb;

    // Seed reduction: one byte per cycle over the 64-bit seed
    localparam int MOD_STEPS = 8;
    localparam int MOD_CNT_W = 4;

    // Register value as used for placement: 0 reads as 1, above 4 as 4
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] v;
        if (r == '0) begin
            v = 3'd1;
        end else if (r > 3'd4) begin
            v = 3'd4;
        end else begin
            v = r;
        end
        return v;
    endfunction

    // Restoring remainder, eight bits MSB first; rem must be below m
    function automatic logic [4:0] mod_byte(input logic [4:0] rem,
                                            input logic [7:0] data_in,
                                            input logic [4:0] m);
        logic [5:0] t;
        logic [4:0] r;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {r, data_in[i]};
            if (t >= {1'b0, m}) begin
                t = t - {1'b0, m};
            end
            r = t[4:0];
        end
        return r;
    endfunction

endpackage

@@ src/pabs_hash.sv @@
// ----------------------------------------------------------------------------
// pabs_hash
// Seed generator: XOR of three splitmix64 finalisers, evaluated on one
// shared 32x32 multiplier, 64-bit products built from three partial products.
// ----------------------------------------------------------------------------
module pabs_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] word_req,
    input  logic [63:0] word_obj,
    input  logic [63:0] word_row,
    output logic        done,
    output logic [63:0] seed
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_LOAD = 3'b010,
        H_MUL  = 3'b100
    } hstate_t;

    hstate_t     state_reg, state_next;
    logic [1:0]  idx_reg;
    logic [1:0]  ph_reg;
    logic        sel_reg;
    logic        done_reg;
    logic [63:0] w_reg [3];
    logic [63:0] a_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] seed_reg;

    logic [63:0] k;
    logic [31:0] op_a;
    logic [31:0] op_k;
    logic [63:0] product;
    logic [63:0] full;
    logic [63:0] v;

    assign k       = sel_reg ? pabs_pkg::MIX_C2 : pabs_pkg::MIX_C1;
    assign op_a    = (ph_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign op_k    = (ph_reg == 2'd1) ? k[63:32] : k[31:0];
    assign product = {32'b0, op_a} * {32'b0, op_k};
    assign full    = acc_reg + {prod_reg[31:0], 32'b0};
    assign v       = w_reg[idx_reg] + pabs_pkg::MIX_GOLD;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            H_IDLE: begin
                if (start) state_next = H_LOAD;
            end
            H_LOAD: begin
                state_next = H_MUL;
            end
            H_MUL: begin
                if (ph_reg == 2'd3 && sel_reg) begin
                    state_next = (idx_reg == 2'd2) ? H_IDLE : H_LOAD;
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            idx_reg   <= '0;
            ph_reg    <= '0;
            sel_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                H_IDLE: begin
                    idx_reg <= '0;
                end
                H_LOAD: begin
                    ph_reg  <= '0;
                    sel_reg <= 1'b0;
                end
                H_MUL: begin
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3) begin
                        if (!sel_reg) begin
                            sel_reg <= 1'b1;
                        end else if (idx_reg == 2'd2) begin
                            done_reg <= 1'b1;
                        end else begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= product;
        if (state_reg == H_IDLE && start) begin
            w_reg[0] <= word_req;
            w_reg[1] <= word_obj;
            w_reg[2] <= word_row;
            seed_reg <= '0;
        end
        if (state_reg == H_LOAD) begin
            a_reg <= v ^ (v >> 30);
        end
        if (state_reg == H_MUL) begin
            unique case (ph_reg)
                2'd1: acc_reg <= prod_reg;
                2'd2: acc_reg <= full;
                2'd3: begin
                    if (!sel_reg) begin
                        a_reg <= full ^ (full >> 27);
                    end else begin
                        seed_reg <= seed_reg ^ full ^ (full >> 31);
                    end
                end
                default: ;
            endcase
        end
    end

    assign done = done_reg;
    assign seed = seed_reg;

endmodule

@@ src/pressure_aware_bank_selector.sv @@
// ----------------------------------------------------------------------------
// pressure_aware_bank_selector
// Free-page table per channel, rank and bank slot; picks the slot with the
// most free pages near a hashed preferred slot and takes one page from it.
// ----------------------------------------------------------------------------
// One item is worked on at a time. After reset the table is zeroed by a
// clearing pass over all CHANNELS*RANKS*MAX_SLOTS entries (64 by default)
// during which no input transfer is taken; configuration writes are taken
// at once. A load item or an out-of-range target goes from idle to the
// result state and then into the output register. A choose item hashes the
// seed with six 64-bit products on one shared 32x32 multiplier, reduces the
// seed modulo the slot count a byte a cycle, then makes one table read per
// slot on the single read port, and ends with one write-back.
// The next input is taken while a result still waits in the output register.
module pressure_aware_bank_selector #(
    parameter int CHANNELS      = pabs_pkg::CHANNELS_DEF,
    parameter int RANKS         = pabs_pkg::RANKS_DEF,
    parameter int MAX_SLOTS     = pabs_pkg::MAX_SLOTS_DEF,
    parameter int ROWS_PER_BANK = pabs_pkg::ROWS_PER_BANK_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pabs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pabs_pkg::CFG_W-1:0]      cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic                            s_channel,
    input  logic                            s_rank_sel,
    input  logic [1:0]                      s_bank_group,
    input  logic [1:0]                      s_bank_sel,
    input  logic [pabs_pkg::CNT_W-1:0]      s_free_count,
    input  logic [15:0]                     s_layer,
    input  logic [15:0]                     s_head,
    input  logic [15:0]                     s_row_index,
    input  logic [2:0]                      s_region_code,
    input  logic [31:0]                     s_request_id,
    input  logic [7:0]                      s_object_id,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [1:0]                      m_chosen_bank_group,
    output logic [1:0]                      m_chosen_bank,
    output logic [pabs_pkg::CNT_W-1:0]      m_chosen_free_before
);

    localparam int DEPTH  = CHANNELS * RANKS * MAX_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_I  = (ROWS_PER_BANK > pabs_pkg::CNT_MAX) ?
                            pabs_pkg::CNT_MAX : ROWS_PER_BANK;
    localparam logic [pabs_pkg::CNT_W-1:0] CAP  = pabs_pkg::CNT_W'(CAP_I);
    localparam logic [ADDR_W-1:0]          LAST = ADDR_W'(DEPTH - 1);
    localparam logic [pabs_pkg::MOD_CNT_W-1:0] MOD_LAST =
        pabs_pkg::MOD_CNT_W'(pabs_pkg::MOD_STEPS);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_MOD    = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [pabs_pkg::CFG_W-1:0] bgc_reg, bkc_reg;
    logic [pabs_pkg::CFG_W-1:0] ngc, nb;
    logic [4:0]                 slots;

    // table
    logic [pabs_pkg::CNT_W-1:0] mem [DEPTH];
    logic [pabs_pkg::CNT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [pabs_pkg::CNT_W-1:0] wr_data;
    logic [ADDR_W-1:0]          clr_reg;

    // input decode
    logic                       accept;
    logic                       tgt_ok;
    logic                       key_ok;
    logic [3:0]                 in_key;
    logic [ADDR_W-1:0]          in_base;
    logic [pabs_pkg::CNT_W-1:0] load_fc;
    logic [4:0]                 in_logical;
    logic                       hash_start;
    logic                       hash_done;
    logic [63:0]                hash_seed;

    // item context
    logic [ADDR_W-1:0]          base_reg;
    logic [4:0]                 slots_reg;
    logic [pabs_pkg::CFG_W-1:0] nb_reg;
    logic [4:0]                 logical_reg;

    // seed reduction
    logic [63:0]                    sh_reg;
    logic [4:0]                     rem_reg;
    logic [pabs_pkg::MOD_CNT_W-1:0] mcnt_reg;
    logic [4:0]                     pref_reg;

    // scan
    logic [4:0]                 scnt_reg;
    logic [1:0]                 g_reg, b_reg;
    logic                       issue;
    logic [4:0]                 slot_dist;
    logic                       p_vld_reg;
    logic                       p_ok_reg;
    logic [4:0]                 p_dist_reg;
    logic [3:0]                 p_key_reg;
    logic                       better;
    logic                       have_reg;
    logic [pabs_pkg::CNT_W-1:0] best_cnt_reg;
    logic [4:0]                 best_dist_reg;
    logic [3:0]                 best_key_reg;

    // result
    logic                       res_found_reg;
    logic [1:0]                 res_bg_reg, res_bk_reg;
    logic [pabs_pkg::CNT_W-1:0] res_before_reg;
    logic                       m_valid_reg;
    logic                       m_found_reg;
    logic [1:0]                 m_bg_reg, m_bk_reg;
    logic [pabs_pkg::CNT_W-1:0] m_before_reg;
    logic                       out_load;

    assign ngc   = pabs_pkg::clamp_cfg(bgc_reg);
    assign nb    = pabs_pkg::clamp_cfg(bkc_reg);
    assign slots = 5'({2'b0, ngc} * {2'b0, nb});

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    assign tgt_ok     = (int'(s_channel) < CHANNELS) && (int'(s_rank_sel) < RANKS);
    assign in_key     = {s_bank_group, s_bank_sel};
    assign key_ok     = int'(in_key) < MAX_SLOTS;
    assign in_base    = ADDR_W'((int'(s_channel) * RANKS + int'(s_rank_sel)) * MAX_SLOTS);
    assign load_fc    = (s_free_count > CAP) ? CAP : s_free_count;
    assign in_logical = 5'({3'b0, s_bank_group} * {2'b0, nb}) + {3'b0, s_bank_sel};
    assign hash_start = accept && s_mode && tgt_ok;

    pabs_hash u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (hash_start),
        .word_req ({32'b0, s_request_id} + 64'd1),
        .word_obj ({53'b0, s_region_code, s_object_id}),
        .word_row ({s_layer, s_head, 15'b0, s_channel, s_row_index}),
        .done     (hash_done),
        .seed     (hash_seed)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bgc_reg <= pabs_pkg::CFG_RESET;
            bkc_reg <= pabs_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pabs_pkg::CFG_BANK_GROUPS: bgc_reg <= cfg_wdata;
                pabs_pkg::CFG_BANKS:       bkc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = '0;
        unique case (state_reg)
            S_CLEAR: wr_en = 1'b1;
            S_IDLE: begin
                if (accept && !s_mode && tgt_ok && key_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = in_base + ADDR_W'(in_key);
                    wr_data = load_fc;
                end
            end
            S_WRITE: begin
                if (have_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = base_reg + ADDR_W'(best_key_reg);
                    wr_data = best_cnt_reg - pabs_pkg::CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign rd_addr = base_reg + ADDR_W'({g_reg, b_reg});

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // scan decode
    assign issue     = (state_reg == S_SCAN) && (scnt_reg != slots_reg);
    assign slot_dist = (scnt_reg >= pref_reg) ? (scnt_reg - pref_reg) :
                       (scnt_reg + slots_reg - pref_reg);
    assign better = p_vld_reg && p_ok_reg && (rd_data_reg != '0) &&
                    (!have_reg || (rd_data_reg > best_cnt_reg) ||
                     ((rd_data_reg == best_cnt_reg) && (p_dist_reg < best_dist_reg)));
    assign out_load = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) state_next = hash_start ? S_HASH : S_RESULT;
            end
            S_HASH: begin
                if (hash_done) state_next = S_MOD;
            end
            S_MOD: begin
                if (mcnt_reg == MOD_LAST) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (scnt_reg == slots_reg && !p_vld_reg) state_next = S_WRITE;
            end
            S_WRITE: state_next = S_RESULT;
            S_RESULT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            p_vld_reg   <= 1'b0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p_vld_reg <= issue;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (state_reg == S_MOD && mcnt_reg == MOD_LAST) begin
                have_reg <= 1'b0;
            end else if (better) begin
                have_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                base_reg       <= in_base;
                slots_reg      <= slots;
                nb_reg         <= nb;
                logical_reg    <= in_logical;
                res_found_reg  <= !s_mode && tgt_ok && key_ok;
                res_bg_reg     <= '0;
                res_bk_reg     <= '0;
                res_before_reg <= '0;
            end
            S_HASH: begin
                sh_reg   <= hash_seed;
                rem_reg  <= '0;
                mcnt_reg <= '0;
            end
            S_MOD: begin
                if (mcnt_reg != MOD_LAST) begin
                    rem_reg  <= pabs_pkg::mod_byte(rem_reg, sh_reg[63:56], slots_reg);
                    sh_reg   <= sh_reg << 8;
                    mcnt_reg <= mcnt_reg + pabs_pkg::MOD_CNT_W'(1);
                end else begin
                    pref_reg <= pabs_pkg::mod_byte(5'd0, {3'b0, logical_reg + rem_reg},
                                                   slots_reg);
                    scnt_reg <= '0;
                    g_reg    <= '0;
                    b_reg    <= '0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    scnt_reg <= scnt_reg + 5'd1;
                    if ({1'b0, b_reg} == nb_reg - 3'd1) begin
                        b_reg <= '0;
                        g_reg <= g_reg + 2'd1;
                    end else begin
                        b_reg <= b_reg + 2'd1;
                    end
                end
            end
            S_WRITE: begin
                res_found_reg  <= have_reg;
                res_bg_reg     <= have_reg ? best_key_reg[3:2] : 2'd0;
                res_bk_reg     <= have_reg ? best_key_reg[1:0] : 2'd0;
                res_before_reg <= have_reg ? best_cnt_reg : '0;
            end
            default: ;
        endcase

        p_ok_reg   <= int'({g_reg, b_reg}) < MAX_SLOTS;
        p_dist_reg <= slot_dist;
        p_key_reg  <= {g_reg, b_reg};
        if (better) begin
            best_cnt_reg  <= rd_data_reg;
            best_dist_reg <= p_dist_reg;
            best_key_reg  <= p_key_reg;
        end

        if (out_load) begin
            m_found_reg  <= res_found_reg;
            m_bg_reg     <= res_bg_reg;
            m_bk_reg     <= res_bk_reg;
            m_before_reg <= res_before_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_found              = m_found_reg;
    assign m_chosen_bank_group  = m_bg_reg;
    assign m_chosen_bank        = m_bk_reg;
    assign m_chosen_free_before = m_before_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_IDLE || state_reg == S_WRITE))
        else $error("table written outside clear, load or write-back");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (pref_reg < slots_reg))
        else $error("preferred slot out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE && have_reg) |-> (best_cnt_reg != '0))
        else $error("empty slot chosen");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && m_valid_reg && !m_ready) |=> (state_reg == S_RESULT))
        else $error("result dropped while output stalled");

endmodule

@@ sim/pabs_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// pabs_tb_pkg
// Item codes shared by the bank selector stimulus and checker.
// ----------------------------------------------------------------------------
package pabs_tb_pkg;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_CHOOSE = 1'b1
    } mode_t;

endpackage

@@ sim/bank_selector_checker.sv @@
// ----------------------------------------------------------------------------
// bank_selector_checker
// Watches the configuration, request and result channels of the bank
// selector, keeps its own free-page table, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bank_selector_checker
    import pabs_pkg::*;
    import pabs_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_mode,
    input  logic                 s_channel,
    input  logic                 s_rank_sel,
    input  logic [1:0]           s_bank_group,
    input  logic [1:0]           s_bank_sel,
    input  logic [CNT_W-1:0]     s_free_count,
    input  logic [15:0]          s_layer,
    input  logic [15:0]          s_head,
    input  logic [15:0]          s_row_index,
    input  logic [2:0]           s_region_code,
    input  logic [31:0]          s_request_id,
    input  logic [7:0]           s_object_id,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_found,
    input  logic [1:0]           m_chosen_bank_group,
    input  logic [1:0]           m_chosen_bank,
    input  logic [CNT_W-1:0]     m_chosen_free_before,

    output int                   failures,
    output int                   outstanding
);

    localparam int CHANNELS    = CHANNELS_DEF;
    localparam int RANKS       = RANKS_DEF;
    localparam int MAX_SLOTS   = MAX_SLOTS_DEF;
    localparam int TABLE_DEPTH = CHANNELS * RANKS * MAX_SLOTS;
    localparam int COUNT_CAP   = (ROWS_PER_BANK_DEF < CNT_MAX) ? ROWS_PER_BANK_DEF : CNT_MAX;

    typedef struct packed {
        logic             found;
        logic [1:0]       grp;
        logic [1:0]       bank;
        logic [CNT_W-1:0] prior;
    } pick_t;

    logic [CNT_W-1:0] page_table [TABLE_DEPTH];
    logic [CFG_W-1:0] groups_reg = CFG_RESET;
    logic [CFG_W-1:0] banks_reg  = CFG_RESET;
    pick_t            pick_q [$];
    pick_t            want;
    pick_t            got;
    int               error_tally = 0;

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] x;
        x = v + MIX_GOLD;
        x = (x ^ (x >> 30)) * MIX_C1;
        x = (x ^ (x >> 27)) * MIX_C2;
        return x ^ (x >> 31);
    endfunction

    // zero reads as one, anything above four as four
    function automatic int unsigned used_count(input logic [CFG_W-1:0] r);
        if (r == '0) begin
            return 1;
        end
        if (r > 3'd4) begin
            return 4;
        end
        return 32'(r);
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_tally++;
        end
    endtask

    // Works out the result of the request on the input port and updates the table
    task automatic predict_pick(output pick_t res);
        int unsigned      base;
        int unsigned      key;
        int unsigned      ngc;
        int unsigned      nb;
        int unsigned      slots;
        int unsigned      slot;
        int unsigned      win_slot;
        int unsigned      win_key;
        logic [63:0]      seed;
        logic [63:0]      logical;
        logic [63:0]      pref;
        logic [63:0]      sdist;
        logic [63:0]      best_dist;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] best_cnt;
        bit               have;

        res = '0;
        if (s_channel >= CHANNELS || s_rank_sel >= RANKS) begin
            return;
        end
        base = (32'(s_channel) * RANKS + 32'(s_rank_sel)) * MAX_SLOTS;

        if (s_mode == MODE_LOAD) begin
            key = 32'(s_bank_group) * 4 + 32'(s_bank_sel);
            if (key >= MAX_SLOTS) begin
                return;
            end
            page_table[base + key] = (s_free_count > COUNT_CAP) ? CNT_W'(COUNT_CAP)
                                                                : s_free_count;
            res.found = 1'b1;
            return;
        end

        ngc   = used_count(groups_reg);
        nb    = used_count(banks_reg);
        slots = ngc * nb;
        seed  = splitmix({32'd0, s_request_id} + 64'd1);
        seed ^= splitmix({53'd0, s_region_code, s_object_id});
        seed ^= splitmix({s_layer, s_head, 15'd0, s_channel, s_row_index});
        logical = 64'(32'(s_bank_group) * nb + 32'(s_bank_sel));
        pref    = (logical + seed % 64'(slots)) % 64'(slots);

        have      = 1'b0;
        best_cnt  = '0;
        best_dist = '0;
        win_slot  = 0;
        win_key   = 0;
        for (slot = 0; slot < slots; slot++) begin
            key = (slot / nb) * 4 + slot % nb;
            if (key >= MAX_SLOTS) begin
                continue;
            end
            cnt = page_table[base + key];
            if (cnt == '0) begin
                continue;
            end
            sdist = (64'(slot) + 64'(slots) - pref) % 64'(slots);
            if (!have || cnt > best_cnt ||
                (cnt == best_cnt && (sdist < best_dist ||
                                     (sdist == best_dist && slot < win_slot)))) begin
                have      = 1'b1;
                best_cnt  = cnt;
                best_dist = sdist;
                win_slot  = slot;
                win_key   = key;
            end
        end
        if (!have) begin
            return;
        end
        page_table[base + win_key] = best_cnt - 1'b1;
        res.found = 1'b1;
        res.grp   = 2'(win_slot / nb);
        res.bank  = 2'(win_slot % nb);
        res.prior = best_cnt;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (page_table[i]) begin
                page_table[i] = '0;
            end
            groups_reg = CFG_RESET;
            banks_reg  = CFG_RESET;
            pick_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BANK_GROUPS) begin
                    groups_reg = cfg_wdata;
                end else if (cfg_index == CFG_BANKS) begin
                    banks_reg = cfg_wdata;
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_found, m_chosen_bank_group, m_chosen_bank, m_chosen_free_before};
                if (pick_q.size() == 0) begin
                    $display("%0t: unexpected result: found %0d group %0d bank %0d free %0d",
                             $time, got.found, got.grp, got.bank, got.prior);
                    error_tally++;
                end else begin
                    want = pick_q.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("chosen_bank_group", want.grp, got.grp);
                    check_field("chosen_bank", want.bank, got.bank);
                    check_field("chosen_free_before", want.prior, got.prior);
                end
            end
            if (s_valid && s_ready) begin
                predict_pick(want);
                pick_q = {pick_q, want};
            end
        end
        failures    <= error_tally;
        outstanding <= pick_q.size();
    end

endmodule

@@ sim/pressure_aware_bank_selector_test.sv @@
// ----------------------------------------------------------------------------
// pressure_aware_bank_selector_test
// Drives loads and bank choices into the selector under several placement
// settings, with random gaps and stalls on both channels; the checker beside
// the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module pressure_aware_bank_selector_test;

    import pabs_pkg::*;
    import pabs_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int ITEMS_PER_PHASE = 190;

    typedef struct {
        mode_t            mode;
        logic             channel;
        logic             rank_sel;
        logic [1:0]       grp_sel;
        logic [1:0]       bank_sel;
        logic [CNT_W-1:0] free_count;
        logic [15:0]      layer;
        logic [15:0]      head;
        logic [15:0]      row_index;
        logic [2:0]       region_code;
        logic [31:0]      req_num;
        logic [7:0]       obj_num;
    } page_request_t;

    logic                 aclk                 = 1'b0;
    logic                 aresetn              = 1'b0;
    logic                 cfg_valid            = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index            = '0;
    logic [CFG_W-1:0]     cfg_wdata            = '0;
    logic                 s_valid              = 1'b0;
    logic                 s_ready;
    logic                 s_mode               = 1'b0;
    logic                 s_channel            = 1'b0;
    logic                 s_rank_sel           = 1'b0;
    logic [1:0]           s_bank_group         = '0;
    logic [1:0]           s_bank_sel           = '0;
    logic [CNT_W-1:0]     s_free_count         = '0;
    logic [15:0]          s_layer              = '0;
    logic [15:0]          s_head               = '0;
    logic [15:0]          s_row_index          = '0;
    logic [2:0]           s_region_code        = '0;
    logic [31:0]          s_request_id         = '0;
    logic [7:0]           s_object_id          = '0;
    logic                 m_valid;
    logic                 m_ready              = 1'b0;
    logic                 m_found;
    logic [1:0]           m_chosen_bank_group;
    logic [1:0]           m_chosen_bank;
    logic [CNT_W-1:0]     m_chosen_free_before;
    int                   failures;
    int                   outstanding;
    bit                   steady               = 1'b0;

    pressure_aware_bank_selector u_top (.*);

    bank_selector_checker u_checker (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic page_request_t request_of(input mode_t mode, input logic ch,
                                                 input logic rk, input logic [1:0] bg,
                                                 input logic [1:0] bk,
                                                 input logic [CNT_W-1:0] fc);
        page_request_t rq;
        rq.mode        = mode;
        rq.channel     = ch;
        rq.rank_sel    = rk;
        rq.grp_sel     = bg;
        rq.bank_sel    = bk;
        rq.free_count  = fc;
        rq.layer       = '0;
        rq.head        = '0;
        rq.row_index   = '0;
        rq.region_code = '0;
        rq.req_num     = '0;
        rq.obj_num     = '0;
        return rq;
    endfunction

    // small counts dominate so that ties and empty banks come up often
    function automatic page_request_t random_request();
        page_request_t rq;
        int r;
        rq.mode        = ($urandom_range(0, 99) < 35) ? MODE_LOAD : MODE_CHOOSE;
        rq.channel     = 1'($urandom_range(0, 1));
        rq.rank_sel    = 1'($urandom_range(0, 1));
        rq.grp_sel     = 2'($urandom_range(0, 3));
        rq.bank_sel    = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 55) begin
            rq.free_count = CNT_W'($urandom_range(1, 3));
        end else if (r < 70) begin
            rq.free_count = '0;
        end else if (r < 90) begin
            rq.free_count = CNT_W'($urandom_range(4, 40));
        end else if (r < 97) begin
            rq.free_count = CNT_W'($urandom_range(41, ROWS_PER_BANK_DEF));
        end else begin
            rq.free_count = CNT_W'($urandom);
        end
        rq.layer       = 16'($urandom);
        rq.head        = 16'($urandom);
        rq.row_index   = 16'($urandom);
        rq.region_code = 3'($urandom);
        rq.req_num     = $urandom;
        rq.obj_num     = 8'($urandom);
        return rq;
    endfunction

    task automatic send_request(input page_request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= rq.mode;
        s_channel     <= rq.channel;
        s_rank_sel    <= rq.rank_sel;
        s_bank_group  <= rq.grp_sel;
        s_bank_sel    <= rq.bank_sel;
        s_free_count  <= rq.free_count;
        s_layer       <= rq.layer;
        s_head        <= rq.head;
        s_row_index   <= rq.row_index;
        s_region_code <= rq.region_code;
        s_request_id  <= rq.req_num;
        s_object_id   <= rq.obj_num;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender until every outstanding result has been transferred
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] groups, input logic [CFG_W-1:0] banks);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BANK_GROUPS;
        cfg_wdata <= groups;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_BANKS;
        cfg_wdata <= banks;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] groups, input logic [CFG_W-1:0] banks);
        int n;
        drain();
        write_config(groups, banks);
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 64 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 149) == 0) begin
                drain();
            end
            send_request(random_request());
        end
    endtask

    task automatic directed_requests();
        page_request_t rq;
        int i;
        // empty table, all-zero hash inputs
        send_request(request_of(MODE_CHOOSE, 1'b0, 1'b0, 2'd0, 2'd0, '0));
        send_request(request_of(MODE_LOAD, 1'b0, 1'b0, 2'd0, 2'd0, '0));
        send_request(request_of(MODE_LOAD, 1'b0, 1'b0, 2'd3, 2'd3, CNT_W'(CNT_MAX)));
        send_request(request_of(MODE_LOAD, 1'b0, 1'b0, 2'd1, 2'd2,
                                CNT_W'(ROWS_PER_BANK_DEF + 1)));
        send_request(request_of(MODE_LOAD, 1'b0, 1'b0, 2'd2, 2'd1,
                                CNT_W'(ROWS_PER_BANK_DEF)));
        // all-ones hash inputs; request id carries into bit 32
        rq = request_of(MODE_CHOOSE, 1'b0, 1'b0, 2'd3, 2'd3, '1);
        rq.layer       = '1;
        rq.head        = '1;
        rq.row_index   = '1;
        rq.region_code = '1;
        rq.req_num     = '1;
        rq.obj_num     = '1;
        send_request(rq);
        send_request(rq);
        // equal counts: order by distance from the preferred slot, then run dry
        for (i = 0; i < 4; i++) begin
            send_request(request_of(MODE_LOAD, 1'b1, 1'b1, 2'(i), 2'(i), CNT_W'(1)));
        end
        repeat (5) begin
            rq          = random_request();
            rq.mode     = MODE_CHOOSE;
            rq.channel  = 1'b1;
            rq.rank_sel = 1'b1;
            send_request(rq);
        end
        send_request(request_of(MODE_LOAD, 1'b1, 1'b0, 2'd3, 2'd0, CNT_W'(1)));
        send_request(request_of(MODE_CHOOSE, 1'b1, 1'b0, 2'd0, 2'd0, '0));
        send_request(request_of(MODE_CHOOSE, 1'b1, 1'b0, 2'd0, 2'd0, '0));
    endtask

    initial begin
        wait (aresetn);
        forever begin
            int stall;
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_config(CFG_RESET, CFG_RESET);
        directed_requests();
        run_phase(3'd1, 3'd1);
        run_phase(3'd0, 3'd7);
        run_phase(3'd7, 3'd0);
        run_phase(3'd2, 3'd3);
        run_phase(3'd4, 3'd4);
        run_phase(3'd3, 3'd1);
        run_phase(3'd6, 3'd2);
        run_phase(3'($urandom), 3'($urandom));
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/pabs_pkg.sv
src/pabs_hash.sv
src/pressure_aware_bank_selector.sv
sim/pabs_tb_pkg.sv
sim/bank_selector_checker.sv
sim/pressure_aware_bank_selector_test.sv
